### design/mpa_pkg.sv
`timescale 1ns / 1ps

package mpa_pkg;

   // Build limits
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_DEPTH  = 64;
   localparam int MAX_POOL   = 8;

   // Field and counter widths
   localparam int VALUE_BITS     = 16;
   localparam int INDEX_BITS     = 22;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
   localparam int CHAN_BITS      = $clog2(MAX_DEPTH);
   localparam int WIN_BITS       = $clog2(MAX_POOL);
   localparam int DIM_BITS       = 9;
   localparam int DEPTH_BITS     = 7;
   localparam int POOL_BITS      = 4;
   localparam int CSR_DATA_BITS  = 9;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IN_WIDTH    = 3'd0,
      REG_IN_HEIGHT   = 3'd1,
      REG_IN_DEPTH    = 3'd2,
      REG_POOL_WIDTH  = 3'd3,
      REG_POOL_HEIGHT = 3'd4
   } csr_reg_type;

   // Effective (clamped) geometry of the feature map and the window
   typedef struct packed {
      logic [DIM_BITS-1:0]   width;
      logic [DIM_BITS-1:0]   height;
      logic [DEPTH_BITS-1:0] depth;
      logic [POOL_BITS-1:0]  pool_w;
      logic [POOL_BITS-1:0]  pool_h;
   } geometry_type;

   // Per-sample control derived from the raster position
   typedef struct packed {
      logic [COL_BITS-1:0]   out_col;
      logic                  first;
      logic                  emit;
      logic                  last;
      logic [INDEX_BITS-1:0] index;
   } sample_ctl_type;

   // One entry of the partial-maximum row buffer
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [INDEX_BITS-1:0]        index;
   } entry_type;

   // Zero acts as one; anything above the limit saturates at the limit.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] raw,
                                                     input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] result;
      if (raw == '0) begin
         result = DIM_BITS'(1);
      end else if (raw > hi) begin
         result = hi;
      end else begin
         result = raw;
      end
      return result;
   endfunction

endpackage

### design/mpa_raster.sv
`timescale 1ns / 1ps

module mpa_raster (
   input  logic                    clock,
   input  logic                    reset,
   input  mpa_pkg::geometry_type   geom,
   input  logic                    restart,
   input  logic                    step,
   output mpa_pkg::sample_ctl_type ctl
);

   logic [mpa_pkg::COL_BITS-1:0]   col_ff, col_in;
   logic [mpa_pkg::ROW_BITS-1:0]   row_ff, row_in;
   logic [mpa_pkg::CHAN_BITS-1:0]  chan_ff, chan_in;
   logic [mpa_pkg::WIN_BITS-1:0]   cwin_ff, cwin_in;
   logic [mpa_pkg::WIN_BITS-1:0]   rwin_ff, rwin_in;
   logic [mpa_pkg::COL_BITS-1:0]   ocol_ff, ocol_in;
   logic [mpa_pkg::INDEX_BITS-1:0] sample_ff, sample_in;

   logic row_end, col_end, chan_end;
   logic cwin_wrap, rwin_wrap;

   always_comb begin
      row_end   = (mpa_pkg::DIM_BITS'(col_ff) + mpa_pkg::DIM_BITS'(1)) >= geom.width;
      col_end   = (mpa_pkg::DIM_BITS'(row_ff) + mpa_pkg::DIM_BITS'(1)) >= geom.height;
      chan_end  = (mpa_pkg::DEPTH_BITS'(chan_ff) + mpa_pkg::DEPTH_BITS'(1)) >= geom.depth;
      cwin_wrap = (mpa_pkg::POOL_BITS'(cwin_ff) + mpa_pkg::POOL_BITS'(1)) >= geom.pool_w;
      rwin_wrap = (mpa_pkg::POOL_BITS'(rwin_ff) + mpa_pkg::POOL_BITS'(1)) >= geom.pool_h;

      ctl.out_col = ocol_ff;
      ctl.first   = (cwin_ff == '0) && (rwin_ff == '0);
      ctl.emit    = (row_end || cwin_wrap) && (col_end || rwin_wrap);
      ctl.last    = row_end && col_end && chan_end;
      ctl.index   = sample_ff;
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      chan_in   = chan_ff;
      cwin_in   = cwin_ff;
      rwin_in   = rwin_ff;
      ocol_in   = ocol_ff;
      sample_in = sample_ff;
      if (restart) begin
         col_in    = '0;
         row_in    = '0;
         chan_in   = '0;
         cwin_in   = '0;
         rwin_in   = '0;
         ocol_in   = '0;
         sample_in = '0;
      end else if (step) begin
         sample_in = ctl.last ? '0 : sample_ff + mpa_pkg::INDEX_BITS'(1);
         if (row_end) begin
            col_in  = '0;
            cwin_in = '0;
            ocol_in = '0;
            if (col_end) begin
               row_in  = '0;
               rwin_in = '0;
               chan_in = chan_end ? '0 : chan_ff + mpa_pkg::CHAN_BITS'(1);
            end else begin
               row_in  = row_ff + mpa_pkg::ROW_BITS'(1);
               rwin_in = rwin_wrap ? '0 : rwin_ff + mpa_pkg::WIN_BITS'(1);
            end
         end else begin
            col_in  = col_ff + mpa_pkg::COL_BITS'(1);
            cwin_in = cwin_wrap ? '0 : cwin_ff + mpa_pkg::WIN_BITS'(1);
            ocol_in = cwin_wrap ? ocol_ff + mpa_pkg::COL_BITS'(1) : ocol_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         chan_ff   <= '0;
         cwin_ff   <= '0;
         rwin_ff   <= '0;
         ocol_ff   <= '0;
         sample_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         chan_ff   <= chan_in;
         cwin_ff   <= cwin_in;
         rwin_ff   <= rwin_in;
         ocol_ff   <= ocol_in;
         sample_ff <= sample_in;
      end
   end

endmodule

### design/mpa_row_mem.sv
`timescale 1ns / 1ps

module mpa_row_mem (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [mpa_pkg::COL_BITS-1:0] rd_addr,
   output mpa_pkg::entry_type           rd_data,
   input  logic                         wr_en,
   input  logic [mpa_pkg::COL_BITS-1:0] wr_addr,
   input  mpa_pkg::entry_type           wr_data
);

   mpa_pkg::entry_type mem [mpa_pkg::MAX_WIDTH];
   mpa_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/max_pool_with_argmax.sv
`timescale 1ns / 1ps

// Streaming 2-D max pooling with argmax. Feature-map samples arrive one per
// request in raster order (channel, then row, then column); non-overlapping
// pool_height x pool_width windows are reduced to their maximum, with partial
// windows at the right and bottom edges. Each result carries the maximum, the
// flat input index of the sample that won (the earliest one on a tie) and a
// flag on the last result of the frame. The block takes one request per
// cycle, sustained while no held result stalls it; the request closing a window
// passes stage 0 and stage 1 before its result reaches the output register.
// These stages are set by the 256-entry row buffer: a read-modify-write per
// sample with a registered read, the write of one sample forwarded to the
// read of the next. A held result stalls the pipeline only once a sample
// that closes a window reaches the stage in front of the output register;
// until then samples keep flowing. Writing any listed register restarts the
// frame; write only while no request is in flight. The row buffer needs no
// clearing pass after reset: each window's first sample discards the entry.
module max_pool_with_argmax (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [mpa_pkg::VALUE_BITS-1:0] req_sample_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mpa_pkg::VALUE_BITS-1:0] rsp_pooled_value,
   output logic [mpa_pkg::INDEX_BITS-1:0]      rsp_source_index,
   output logic                                rsp_frame_last,
   input  logic                                csr_write_enable,
   input  logic [mpa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mpa_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   // Geometry registers, stored already clamped
   mpa_pkg::geometry_type geom_ff, geom_in;
   logic                  restart;

   // Stage 0: accepted request plus its window control
   logic                         s0_valid_ff;
   logic signed [mpa_pkg::VALUE_BITS-1:0] s0_value_ff;
   mpa_pkg::sample_ctl_type      s0_ctl_ff;
   mpa_pkg::sample_ctl_type      raster_ctl;

   // Stage 1: row buffer entry available, compare and write back
   logic                         s1_valid_ff;
   logic signed [mpa_pkg::VALUE_BITS-1:0] s1_value_ff;
   mpa_pkg::sample_ctl_type      s1_ctl_ff;
   logic                         fwd_ff, fwd_in;
   mpa_pkg::entry_type           fwd_entry_ff;
   mpa_pkg::entry_type           rd_entry;
   mpa_pkg::entry_type           cur_entry;
   mpa_pkg::entry_type           new_entry;

   // Result register
   logic                         rsp_valid_ff;
   logic signed [mpa_pkg::VALUE_BITS-1:0] rsp_pooled_value_ff;
   logic [mpa_pkg::INDEX_BITS-1:0] rsp_source_index_ff;
   logic                         rsp_frame_last_ff;

   // Flow control
   logic out_free, s1_go, s1_free, s0_go, s0_free, accept;

   // ------------------------------------------------------------------
   // Configuration: mask to the register width, clamp, restart the frame
   // ------------------------------------------------------------------
   always_comb begin
      geom_in = geom_ff;
      restart = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            mpa_pkg::REG_IN_WIDTH: begin
               geom_in.width = mpa_pkg::clamp_dim(csr_write_data,
                                                  mpa_pkg::DIM_BITS'(mpa_pkg::MAX_WIDTH));
               restart = 1'b1;
            end
            mpa_pkg::REG_IN_HEIGHT: begin
               geom_in.height = mpa_pkg::clamp_dim(csr_write_data,
                                                   mpa_pkg::DIM_BITS'(mpa_pkg::MAX_HEIGHT));
               restart = 1'b1;
            end
            mpa_pkg::REG_IN_DEPTH: begin
               geom_in.depth = mpa_pkg::DEPTH_BITS'(mpa_pkg::clamp_dim(
                  mpa_pkg::DIM_BITS'(csr_write_data[mpa_pkg::DEPTH_BITS-1:0]),
                  mpa_pkg::DIM_BITS'(mpa_pkg::MAX_DEPTH)));
               restart = 1'b1;
            end
            mpa_pkg::REG_POOL_WIDTH: begin
               geom_in.pool_w = mpa_pkg::POOL_BITS'(mpa_pkg::clamp_dim(
                  mpa_pkg::DIM_BITS'(csr_write_data[mpa_pkg::POOL_BITS-1:0]),
                  mpa_pkg::DIM_BITS'(mpa_pkg::MAX_POOL)));
               restart = 1'b1;
            end
            mpa_pkg::REG_POOL_HEIGHT: begin
               geom_in.pool_h = mpa_pkg::POOL_BITS'(mpa_pkg::clamp_dim(
                  mpa_pkg::DIM_BITS'(csr_write_data[mpa_pkg::POOL_BITS-1:0]),
                  mpa_pkg::DIM_BITS'(mpa_pkg::MAX_POOL)));
               restart = 1'b1;
            end
            default: begin
               // unlisted index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.width  <= mpa_pkg::DIM_BITS'(1);
         geom_ff.height <= mpa_pkg::DIM_BITS'(1);
         geom_ff.depth  <= mpa_pkg::DEPTH_BITS'(1);
         geom_ff.pool_w <= mpa_pkg::POOL_BITS'(2);
         geom_ff.pool_h <= mpa_pkg::POOL_BITS'(2);
      end else begin
         geom_ff <= geom_in;
      end
   end

   // ------------------------------------------------------------------
   // Flow control: a stage advances when the stage after it can take it.
   // Only a result-carrying item in stage 1 needs the output register.
   // ------------------------------------------------------------------
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      s1_go    = s1_valid_ff && (!s1_ctl_ff.emit || out_free);
      s1_free  = !s1_valid_ff || s1_go;
      s0_go    = s0_valid_ff && s1_free;
      s0_free  = !s0_valid_ff || s0_go;
      accept   = req_valid && s0_free;
   end

   assign req_ready = s0_free;

   // Raster position advances once per accepted request
   mpa_raster u_raster (
      .clock   (clock),
      .reset   (reset),
      .geom    (geom_ff),
      .restart (restart),
      .step    (accept),
      .ctl     (raster_ctl)
   );

   // ------------------------------------------------------------------
   // Stage 0
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_free) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_value_ff <= req_sample_value;
         s0_ctl_ff   <= raster_ctl;
      end
   end

   // Row buffer: read for stage 0 as it advances, write back from stage 1
   mpa_row_mem u_row_mem (
      .clock   (clock),
      .rd_en   (s0_go),
      .rd_addr (s0_ctl_ff.out_col),
      .rd_data (rd_entry),
      .wr_en   (s1_go),
      .wr_addr (s1_ctl_ff.out_col),
      .wr_data (new_entry)
   );

   // ------------------------------------------------------------------
   // Stage 1: running max update. The entry written at the same edge as
   // the read is not in the read data yet; forward it.
   // ------------------------------------------------------------------
   always_comb begin
      cur_entry = fwd_ff ? fwd_entry_ff : rd_entry;
      if (s1_ctl_ff.first || (s1_value_ff > cur_entry.value)) begin
         new_entry.value = s1_value_ff;
         new_entry.index = s1_ctl_ff.index;
      end else begin
         new_entry = cur_entry;
      end
      fwd_in = s1_go && (s1_ctl_ff.out_col == s0_ctl_ff.out_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_go) begin
         s1_value_ff  <= s0_value_ff;
         s1_ctl_ff    <= s0_ctl_ff;
         fwd_ff       <= fwd_in;
         fwd_entry_ff <= new_entry;
      end
   end

   // ------------------------------------------------------------------
   // Result register: load when a closing sample leaves stage 1,
   // hold until taken
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_ctl_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_ctl_ff.emit) begin
         rsp_pooled_value_ff <= new_entry.value;
         rsp_source_index_ff <= new_entry.index;
         rsp_frame_last_ff   <= s1_ctl_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = rsp_pooled_value_ff;
   assign rsp_source_index = rsp_source_index_ff;
   assign rsp_frame_last   = rsp_frame_last_ff;

endmodule

### design/mpa_checker.sv
`timescale 1ns / 1ps

module mpa_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [mpa_pkg::VALUE_BITS-1:0] rsp_pooled_value,
   input logic [mpa_pkg::INDEX_BITS-1:0]        rsp_source_index,
   input logic                                  rsp_frame_last
);

   // Reset empties the result register.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_pooled_value) && $stable(rsp_source_index)
          && $stable(rsp_frame_last)))
      else $error("held result changed");

   // With the output side free, the pipeline drains and requests are taken.
   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled while output side free");

endmodule

bind max_pool_with_argmax mpa_checker u_mpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pooled_value (rsp_pooled_value),
   .rsp_source_index (rsp_source_index),
   .rsp_frame_last   (rsp_frame_last)
);
